// ----- rtl/tpa_pkg.sv -----
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared widths, register indexes and constants of the triangle primitive
// assembler.
// ----------------------------------------------------------------------------
package tpa_pkg;

  localparam int INDEX_W   = 32;
  localparam int COUNT_W   = 16;
  localparam int POS_W     = 18;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // The 16-bit count register can never exceed this limit.
  localparam int MAX_PRIMITIVES = 65535;

  // Primitive modes.
  localparam logic [MODE_W-1:0] MODE_LIST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STRIP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FAN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OTHER = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PRIM_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIM_COUNT = 2'd1;

  localparam logic [INDEX_W-1:0] RESTART16   = 32'h0000_FFFF;
  localparam logic [INDEX_W-1:0] RESTART32   = 32'hFFFF_FFFF;
  localparam logic [POS_W-1:0]   COUNTER_MAX = 18'h3FFFF;

  typedef struct packed {
    logic [INDEX_W-1:0] a;
    logic [INDEX_W-1:0] b;
    logic [INDEX_W-1:0] c;
  } tri_t;

  function automatic logic is_restart(input logic [INDEX_W-1:0] v);
    return (v == RESTART16) || (v == RESTART32);
  endfunction

endpackage

// ----- rtl/triangle_primitive_assembler.sv -----
// ----------------------------------------------------------------------------
// triangle_primitive_assembler
// Turns a stream of vertex indices into a triangle list (list, strip, fan).
// ----------------------------------------------------------------------------
// The block takes one vertex index per clock while in_stall is low and emits
// at most one triangle per index, written into an output register backed by a
// one-entry skid register when the index is accepted. The decision for an
// index is a handful of compares against the two previous indices, the fan
// root and a position counter, all held in registers, so the sustained rate
// is one index per cycle while out_stall is low. in_stall rises only when
// both registers are full. Configuration writes are always ready and take
// effect for the next accepted index.
module triangle_primitive_assembler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tpa_pkg::INDEX_W-1:0]    vertex_index,
  input  logic                           draw_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tpa_pkg::INDEX_W-1:0]    corner_a,
  output logic [tpa_pkg::INDEX_W-1:0]    corner_b,
  output logic [tpa_pkg::INDEX_W-1:0]    corner_c,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpa_pkg::CFG_DAT_W-1:0]  cfg_data
);

  logic [tpa_pkg::MODE_W-1:0]  prim_mode;
  logic [tpa_pkg::COUNT_W-1:0] prim_count;
  logic [tpa_pkg::INDEX_W-1:0] older_index;
  logic [tpa_pkg::INDEX_W-1:0] newer_index;
  logic [tpa_pkg::INDEX_W-1:0] fan_root;
  logic [tpa_pkg::POS_W-1:0]   index_counter;
  logic [1:0]                  phase;

  tpa_pkg::tri_t out_tri;
  tpa_pkg::tri_t skid_tri;
  logic          skid_valid;

  logic                        in_accept;
  logic                        out_fire;
  logic [tpa_pkg::POS_W-1:0]   pos;
  logic [1:0]                  pos_phase;
  logic [tpa_pkg::POS_W-1:0]   list_limit;
  logic [tpa_pkg::POS_W-1:0]   tri_limit;
  logic                        emit;
  tpa_pkg::tri_t               new_tri;
  logic                        degen_ab;
  logic                        degen_bc;
  logic                        degen_ac;
  logic                        degen_rb;
  logic                        degen_rc;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign corner_a  = out_tri.a;
  assign corner_b  = out_tri.b;
  assign corner_c  = out_tri.c;

  assign pos       = draw_start ? '0 : index_counter;
  assign pos_phase = draw_start ? 2'd0 : phase;

  // Three times the count, and the count plus two, both fit in the position
  // width, so the range checks are plain compares.
  assign list_limit = {2'b00, prim_count} + {1'b0, prim_count, 1'b0};
  assign tri_limit  = {2'b00, prim_count} + tpa_pkg::POS_W'(2);

  assign degen_ab = (older_index == newer_index);
  assign degen_bc = (newer_index == vertex_index);
  assign degen_ac = (older_index == vertex_index);
  assign degen_rb = (fan_root == newer_index);
  assign degen_rc = (fan_root == vertex_index);

  always_comb begin
    emit      = 1'b0;
    new_tri.a = older_index;
    new_tri.b = newer_index;
    new_tri.c = vertex_index;
    unique case (prim_mode)
      tpa_pkg::MODE_LIST: begin
        emit = (pos_phase == 2'd2) && (pos < list_limit);
      end
      tpa_pkg::MODE_STRIP: begin
        emit = (pos >= tpa_pkg::POS_W'(2)) && (pos < tri_limit) &&
               !degen_ab && !degen_bc && !degen_ac &&
               !tpa_pkg::is_restart(older_index) &&
               !tpa_pkg::is_restart(newer_index) &&
               !tpa_pkg::is_restart(vertex_index);
        // Odd triangles of a strip swap their first two corners.
        if (pos[0]) begin
          new_tri.a = newer_index;
          new_tri.b = older_index;
        end
      end
      tpa_pkg::MODE_FAN: begin
        // From position two on, the root is always the stored one.
        new_tri.a = fan_root;
        emit = (pos >= tpa_pkg::POS_W'(2)) && (pos < tri_limit) &&
               !degen_rb && !degen_bc && !degen_rc;
      end
      tpa_pkg::MODE_OTHER: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prim_mode  <= tpa_pkg::MODE_LIST;
      prim_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tpa_pkg::REG_PRIM_MODE) begin
        prim_mode <= cfg_data[tpa_pkg::MODE_W-1:0];
      end else if (cfg_index == tpa_pkg::REG_PRIM_COUNT) begin
        prim_count <= cfg_data[tpa_pkg::COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_index   <= '0;
      newer_index   <= '0;
      fan_root      <= '0;
      index_counter <= '0;
      phase         <= 2'd0;
    end else if (in_accept) begin
      if (pos == '0) begin
        fan_root <= vertex_index;
      end
      older_index   <= newer_index;
      newer_index   <= vertex_index;
      index_counter <= (pos >= tpa_pkg::COUNTER_MAX) ? tpa_pkg::COUNTER_MAX
                                                     : pos + tpa_pkg::POS_W'(1);
      phase         <= (pos_phase == 2'd2) ? 2'd0 : pos_phase + 2'd1;
    end
  end

  // Output register with a one-entry skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_tri    <= skid_tri;
        skid_valid <= 1'b0;
      end
    end else if (in_accept && emit) begin
      if (!out_valid || out_fire) begin
        out_tri   <= new_tri;
        out_valid <= 1'b1;
      end else begin
        skid_tri   <= new_tri;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // The skid entry is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while output register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_stall |=> skid_valid)
    else $error("skid entry lost while output stalled");

  a_draw_start_pos: assert property (@(posedge clk) disable iff (rst)
    in_accept && draw_start |=> (index_counter == tpa_pkg::POS_W'(1)) &&
                                (phase == 2'd1))
    else $error("position not restarted by draw start");

  a_phase_origin: assert property (@(posedge clk) disable iff (rst)
    (index_counter == '0) |-> (phase == 2'd0))
    else $error("list phase out of step with position counter");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("list phase left its range");

endmodule
